@@ rtl/core/bz2x_pkg.sv @@
// Shared constants, types and channel arithmetic for the 2x bilinear RGBA upscaler.
`default_nettype none
package bz2x_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 32;
  localparam int SW_W       = 12;
  localparam int SH_W       = 13;
  localparam int DROW_W     = 13;
  localparam int DCOL_W     = 12;
  localparam int CFG_D_W    = 13;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [0:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [0:0] REG_SRC_HEIGHT = 1'b1;

  localparam logic [SW_W-1:0] SRC_WIDTH_RST  = SW_W'(640);
  localparam logic [SH_W-1:0] SRC_HEIGHT_RST = SH_W'(480);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             frame_end;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] left_above;
  } job_t;

  function automatic logic [PIX_W-1:0] mean2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [8:0]       s;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8:1];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] mean4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] r;
    logic [9:0]       s;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      s = {2'b0, a[8*k +: 8]} + {2'b0, b[8*k +: 8]} +
          {2'b0, c[8*k +: 8]} + {2'b0, d[8*k +: 8]};
      r[8*k +: 8] = s[9:2];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] width_last(input logic [SW_W-1:0] w);
    logic [COL_W-1:0] r;
    if (w < SW_W'(2)) begin
      r = COL_W'(1);
    end else if (w > SW_W'(MAX_WIDTH)) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(w - SW_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [SH_W-1:0] h);
    logic [ROW_W-1:0] r;
    if (h < SH_W'(2)) begin
      r = ROW_W'(1);
    end else if (h > SH_W'(MAX_HEIGHT)) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(h - SH_W'(1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bz2x_front.sv @@
// Front end: config registers, raster counters, line buffer and job assembly.
`default_nettype none
module bz2x_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [0:0]                   cfg_index,
  input  wire  [bz2x_pkg::CFG_D_W-1:0] cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [bz2x_pkg::PIX_W-1:0]   in_src_pixel,
  output logic                         job_valid,
  input  wire                          job_ready,
  output bz2x_pkg::job_t               job
);

  logic [bz2x_pkg::COL_W-1:0] wlast_r;
  logic [bz2x_pkg::ROW_W-1:0] hlast_r;
  logic [bz2x_pkg::COL_W-1:0] col_r;
  logic [bz2x_pkg::ROW_W-1:0] row_r;
  logic [bz2x_pkg::COL_W-1:0] col_nxt;
  logic [bz2x_pkg::ROW_W-1:0] row_nxt;

  logic                       s1_v_r;
  logic [bz2x_pkg::ROW_W-1:0] s1_row_r;
  logic [bz2x_pkg::COL_W-1:0] s1_col_r;
  logic                       s1_lastc_r;
  logic                       s1_done_r;
  logic [bz2x_pkg::PIX_W-1:0] s1_cur_r;
  logic [bz2x_pkg::PIX_W-1:0] rd_r;
  logic [bz2x_pkg::PIX_W-1:0] left_r;
  logic [bz2x_pkg::PIX_W-1:0] left_above_r;

  logic [bz2x_pkg::PIX_W-1:0] line_mem [bz2x_pkg::MAX_WIDTH];

  logic acc;
  logic adv;
  logic cfg_acc;
  logic last_c;
  logic last_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign adv       = s1_v_r && job_ready;
  assign in_ready  = !s1_v_r || job_ready;
  assign acc       = in_valid && in_ready;
  assign last_c    = col_r >= wlast_r;
  assign last_r    = row_r >= hlast_r;

  always_comb begin
    col_nxt = col_r + bz2x_pkg::COL_W'(1);
    row_nxt = row_r;
    if (last_c) begin
      col_nxt = '0;
      row_nxt = last_r ? '0 : row_r + bz2x_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r      <= bz2x_pkg::width_last(bz2x_pkg::SRC_WIDTH_RST);
      hlast_r      <= bz2x_pkg::height_last(bz2x_pkg::SRC_HEIGHT_RST);
      col_r        <= '0;
      row_r        <= '0;
      s1_v_r       <= 1'b0;
      left_r       <= '0;
      left_above_r <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          bz2x_pkg::REG_SRC_WIDTH: begin
            wlast_r <= bz2x_pkg::width_last(cfg_data[bz2x_pkg::SW_W-1:0]);
          end
          bz2x_pkg::REG_SRC_HEIGHT: begin
            hlast_r <= bz2x_pkg::height_last(cfg_data);
          end
          default: begin
          end
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        left_r       <= s1_cur_r;
        left_above_r <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_lastc_r <= last_c;
      s1_done_r  <= last_c && last_r;
      s1_cur_r   <= in_src_pixel;
    end
  end

  // read-first: the entry returns the pixel above before it is replaced
  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[col_r] <= in_src_pixel;
      rd_r            <= line_mem[col_r];
    end
  end

  assign job_valid      = s1_v_r;
  assign job.row        = s1_row_r;
  assign job.col        = s1_col_r;
  assign job.last_col   = s1_lastc_r;
  assign job.frame_end  = s1_done_r;
  assign job.cur        = s1_cur_r;
  assign job.above      = rd_r;
  assign job.left       = left_r;
  assign job.left_above = left_above_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r) else $error("column counter beyond row end");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hlast_r) else $error("row counter beyond frame end");

endmodule
`default_nettype wire

@@ rtl/core/bz2x_queue.sv @@
// Short job queue between the front end and the result sequencer.
`default_nettype none
module bz2x_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push_valid,
  output logic           push_ready,
  input  bz2x_pkg::job_t push_data,
  output logic           pop_valid,
  input  wire            pop_ready,
  output bz2x_pkg::job_t pop_data
);

  bz2x_pkg::job_t                 slot_r [bz2x_pkg::Q_DEPTH];
  logic [bz2x_pkg::Q_PTR_W-1:0]   wr_r;
  logic [bz2x_pkg::Q_PTR_W-1:0]   rd_r;
  logic [bz2x_pkg::Q_PTR_W:0]     cnt_r;
  logic                           push;
  logic                           pop;

  assign push_ready = cnt_r != (bz2x_pkg::Q_PTR_W+1)'(bz2x_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + bz2x_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + bz2x_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (bz2x_pkg::Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (bz2x_pkg::Q_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (bz2x_pkg::Q_PTR_W+1)'(bz2x_pkg::Q_DEPTH)) else $error("queue overflow");

endmodule
`default_nettype wire

@@ rtl/core/bz2x_back.sv @@
// Back end: walks each job through its destination pixels, one per cycle while the output is not stalled.
`default_nettype none
module bz2x_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         job_valid,
  output logic                        job_ready,
  input  bz2x_pkg::job_t              job,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [bz2x_pkg::DROW_W-1:0] out_dst_row,
  output logic [bz2x_pkg::DCOL_W-1:0] out_dst_col,
  output logic [bz2x_pkg::PIX_W-1:0]  out_dst_pixel,
  output logic                        out_last_of_item,
  output logic                        out_frame_done
);

  typedef enum logic [1:0] {
    POS_MID,
    POS_MAIN,
    POS_COPY
  } pos_t;

  pos_t pos_r;
  pos_t pos_eff;
  logic line_r;
  logic out_v_r;
  logic [bz2x_pkg::DROW_W-1:0] row_o_r;
  logic [bz2x_pkg::DCOL_W-1:0] col_o_r;
  logic [bz2x_pkg::PIX_W-1:0]  pix_o_r;
  logic                        last_o_r;
  logic                        done_o_r;

  logic load;
  logic line_end;
  logic [bz2x_pkg::PIX_W-1:0]  hmid;
  logic [bz2x_pkg::PIX_W-1:0]  vmid;
  logic [bz2x_pkg::PIX_W-1:0]  ctr;
  logic [bz2x_pkg::PIX_W-1:0]  mid_px;
  logic [bz2x_pkg::PIX_W-1:0]  main_px;
  logic [bz2x_pkg::PIX_W-1:0]  pix_sel;
  logic [bz2x_pkg::DROW_W-1:0] row_sel;
  logic [bz2x_pkg::DCOL_W-1:0] col_sel;

  assign load      = job_valid && (!out_v_r || out_ready);
  assign pos_eff   = (pos_r == POS_MID && job.col == '0) ? POS_MAIN : pos_r;
  assign line_end  = (pos_eff == POS_COPY) || (pos_eff == POS_MAIN && !job.last_col);
  assign job_ready = load && line_r && line_end;

  assign hmid = bz2x_pkg::mean2(job.left, job.cur);
  assign vmid = bz2x_pkg::mean2(job.above, job.cur);
  assign ctr  = bz2x_pkg::mean4(job.left_above, job.above, job.left, job.cur);

  always_comb begin
    if (!line_r && job.row != '0) begin
      mid_px  = ctr;
      main_px = vmid;
      row_sel = {job.row, 1'b0};
    end else begin
      mid_px  = hmid;
      main_px = job.cur;
      row_sel = line_r ? {job.row, 1'b1} : '0;
    end
    case (pos_eff)
      POS_MID: begin
        pix_sel = mid_px;
        col_sel = {job.col - bz2x_pkg::COL_W'(1), 1'b1};
      end
      POS_MAIN: begin
        pix_sel = main_px;
        col_sel = {job.col, 1'b0};
      end
      POS_COPY: begin
        pix_sel = main_px;
        col_sel = {job.col, 1'b1};
      end
      default: begin
        pix_sel = main_px;
        col_sel = {job.col, 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_MID;
      line_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        out_v_r  <= 1'b1;
        row_o_r  <= row_sel;
        col_o_r  <= col_sel;
        pix_o_r  <= pix_sel;
        last_o_r <= line_r && line_end;
        done_o_r <= line_r && line_end && job.frame_end;
        if (line_end) begin
          pos_r  <= POS_MID;
          line_r <= !line_r;
        end else if (pos_eff == POS_MID) begin
          pos_r <= POS_MAIN;
        end else begin
          pos_r <= POS_COPY;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_dst_row      = row_o_r;
  assign out_dst_col      = col_o_r;
  assign out_dst_pixel    = pix_o_r;
  assign out_last_of_item = last_o_r;
  assign out_frame_done   = done_o_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && done_o_r |-> last_o_r) else $error("frame end not on item end");
  a_second_line_odd: assert property (@(posedge clk) disable iff (!rst_n)
    load && line_r |=> row_o_r[0]) else $error("second line row not odd");

endmodule
`default_nettype wire

@@ rtl/core/bilinear_zoom_2x_rgba_top.sv @@
// Top level of the 2x bilinear RGBA upscaler.
// A source pixel passes the front-end stage register, a queue slot and the output
// register before its first result is valid. Throughput: one result per cycle while
// the output is not stalled; a source pixel yields 2 to 6 results, 4 typical. A 4-entry
// job queue lets the front end keep accepting while the output stalls.
// Reset: sizes return to 640x480 and counters to zero; the line buffer is not cleared.
`default_nettype none
module bilinear_zoom_2x_rgba_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [0:0]                   cfg_index,
  input  wire  [bz2x_pkg::CFG_D_W-1:0] cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [bz2x_pkg::PIX_W-1:0]   in_src_pixel,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bz2x_pkg::DROW_W-1:0]  out_dst_row,
  output logic [bz2x_pkg::DCOL_W-1:0]  out_dst_col,
  output logic [bz2x_pkg::PIX_W-1:0]   out_dst_pixel,
  output logic                         out_last_of_item,
  output logic                         out_frame_done
);

  logic           fq_valid;
  logic           fq_ready;
  bz2x_pkg::job_t fq_job;
  logic           qb_valid;
  logic           qb_ready;
  bz2x_pkg::job_t qb_job;

  bz2x_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_pixel (in_src_pixel),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job          (fq_job)
  );

  bz2x_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  bz2x_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (qb_valid),
    .job_ready        (qb_ready),
    .job              (qb_job),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dst_row      (out_dst_row),
    .out_dst_col      (out_dst_col),
    .out_dst_pixel    (out_dst_pixel),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the 2x bilinear RGBA upscaler: directed corners, random frames.
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 82;
  localparam int PRESS_ITEMS    = 16;

  typedef struct {
    logic [bz2x_pkg::DROW_W-1:0] row;
    logic [bz2x_pkg::DCOL_W-1:0] col;
    logic [bz2x_pkg::PIX_W-1:0]  pixel;
    logic                        last;
    logic                        done;
  } dst_px_t;

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [0:0]                   cfg_index    = bz2x_pkg::REG_SRC_WIDTH;
  logic [bz2x_pkg::CFG_D_W-1:0] cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic [bz2x_pkg::PIX_W-1:0]   in_src_pixel = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic [bz2x_pkg::DROW_W-1:0]  out_dst_row;
  logic [bz2x_pkg::DCOL_W-1:0]  out_dst_col;
  logic [bz2x_pkg::PIX_W-1:0]   out_dst_pixel;
  logic                         out_last_of_item;
  logic                         out_frame_done;

  bilinear_zoom_2x_rgba_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_pixel     (in_src_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dst_row      (out_dst_row),
    .out_dst_col      (out_dst_col),
    .out_dst_pixel    (out_dst_pixel),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

  logic [bz2x_pkg::PIX_W-1:0] src_pixels_q[$];
  dst_px_t                    upscaled_q[$];
  int                         items_pushed  = 0;
  int                         items_taken   = 0;
  int                         errors        = 0;
  int                         quiet_cycles  = 0;
  int                         in_idle_pct   = 0;
  int                         out_stall_pct = 0;
  int                         hold_left     = 0;
  logic                       hold_req      = 1'b0;
  logic                       hold_seen     = 1'b0;
  logic                       in_acc        = 1'b0;
  logic                       cfg_acc       = 1'b0;

  logic [bz2x_pkg::SW_W-1:0]  width_reg     = bz2x_pkg::SRC_WIDTH_RST;
  logic [bz2x_pkg::SH_W-1:0]  height_reg    = bz2x_pkg::SRC_HEIGHT_RST;
  logic [bz2x_pkg::PIX_W-1:0] line_mem [bz2x_pkg::MAX_WIDTH];
  logic [bz2x_pkg::PIX_W-1:0] left_px       = '0;
  logic [bz2x_pkg::PIX_W-1:0] left_above_px = '0;
  int                         row_cnt       = 0;
  int                         col_cnt       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_size(input int v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [bz2x_pkg::PIX_W-1:0] avg2(input logic [bz2x_pkg::PIX_W-1:0] a,
                                                      input logic [bz2x_pkg::PIX_W-1:0] b);
    logic [bz2x_pkg::PIX_W-1:0] res;
    int sum;
    for (int k = 0; k < 4; k++) begin
      sum = int'(a[8*k +: 8]) + int'(b[8*k +: 8]);
      res[8*k +: 8] = 8'(sum / 2);
    end
    return res;
  endfunction

  function automatic logic [bz2x_pkg::PIX_W-1:0] avg4(input logic [bz2x_pkg::PIX_W-1:0] a,
                                                      input logic [bz2x_pkg::PIX_W-1:0] b,
                                                      input logic [bz2x_pkg::PIX_W-1:0] c,
                                                      input logic [bz2x_pkg::PIX_W-1:0] d);
    logic [bz2x_pkg::PIX_W-1:0] res;
    int sum;
    for (int k = 0; k < 4; k++) begin
      sum = int'(a[8*k +: 8]) + int'(b[8*k +: 8]) + int'(c[8*k +: 8]) + int'(d[8*k +: 8]);
      res[8*k +: 8] = 8'(sum / 4);
    end
    return res;
  endfunction

  function automatic logic [bz2x_pkg::PIX_W-1:0] rand_pixel();
    logic [bz2x_pkg::PIX_W-1:0] p;
    p = $urandom;
    if ($urandom_range(3) == 0) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: p[8*k +: 8] = 8'h00;
          1: p[8*k +: 8] = 8'hFF;
          2: p[8*k +: 8] = 8'h01;
          default: p[8*k +: 8] = 8'hFE;
        endcase
      end
    end
    return p;
  endfunction

  task automatic push_dst(input int row, input int col, input logic [bz2x_pkg::PIX_W-1:0] px,
                          input logic last, input logic done);
    dst_px_t e;
    e.row   = bz2x_pkg::DROW_W'(row);
    e.col   = bz2x_pkg::DCOL_W'(col);
    e.pixel = px;
    e.last  = last;
    e.done  = done;
    upscaled_q.push_back(e);
  endtask

  task automatic emit_line(input int row, input int c, input logic last_c,
                           input logic [bz2x_pkg::PIX_W-1:0] mid,
                           input logic [bz2x_pkg::PIX_W-1:0] main_px,
                           input logic tail, input logic frame_end);
    if (c >= 1) push_dst(row, 2 * c - 1, mid, 1'b0, 1'b0);
    push_dst(row, 2 * c, main_px, tail & ~last_c, 1'b0);
    if (last_c) push_dst(row, 2 * c + 1, main_px, tail, tail & frame_end);
  endtask

  task automatic upscale_pixel(input logic [bz2x_pkg::PIX_W-1:0] cur);
    int w, h, r, c;
    logic last_c, last_r;
    logic [bz2x_pkg::PIX_W-1:0] above, hmid;
    w = clamp_size(int'(width_reg), bz2x_pkg::MAX_WIDTH);
    h = clamp_size(int'(height_reg), bz2x_pkg::MAX_HEIGHT);
    r = row_cnt;
    c = col_cnt;
    last_c = (c >= w - 1);
    last_r = (r >= h - 1);
    above = line_mem[c];
    hmid = avg2(left_px, cur);
    if (r == 0) begin
      emit_line(0, c, last_c, hmid, cur, 1'b0, 1'b0);
    end else begin
      emit_line(2 * r, c, last_c, avg4(left_above_px, above, left_px, cur), avg2(above, cur),
                1'b0, 1'b0);
    end
    emit_line(2 * r + 1, c, last_c, hmid, cur, 1'b1, last_r);
    left_above_px = above;
    left_px = cur;
    line_mem[c] = cur;
    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic apply_reg(input logic [0:0] idx, input logic [bz2x_pkg::CFG_D_W-1:0] val);
    if (idx == bz2x_pkg::REG_SRC_WIDTH) begin
      width_reg = val[bz2x_pkg::SW_W-1:0];
    end else begin
      height_reg = val[bz2x_pkg::SH_W-1:0];
    end
    row_cnt = 0;
    col_cnt = 0;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_result();
    dst_px_t e;
    if (upscaled_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction row %0d col %0d",
                                out_dst_row, out_dst_col));
    end else begin
      e = upscaled_q.pop_front();
      if (out_dst_row !== e.row)
        report_mismatch($sformatf("dst_row got %0d want %0d", out_dst_row, e.row));
      if (out_dst_col !== e.col)
        report_mismatch($sformatf("dst_col got %0d want %0d (row %0d)",
                                  out_dst_col, e.col, e.row));
      if (out_dst_pixel !== e.pixel)
        report_mismatch($sformatf("dst_pixel got %h want %h at (%0d,%0d)",
                                  out_dst_pixel, e.pixel, e.row, e.col));
      if (out_last_of_item !== e.last)
        report_mismatch($sformatf("last_of_item got %b want %b at (%0d,%0d)",
                                  out_last_of_item, e.last, e.row, e.col));
      if (out_frame_done !== e.done)
        report_mismatch($sformatf("frame_done got %b want %b at (%0d,%0d)",
                                  out_frame_done, e.done, e.row, e.col));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = bz2x_pkg::SRC_WIDTH_RST;
      height_reg = bz2x_pkg::SRC_HEIGHT_RST;
      left_px = '0;
      left_above_px = '0;
      row_cnt = 0;
      col_cnt = 0;
      in_acc <= 1'b0;
      cfg_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      cfg_acc <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        upscale_pixel(in_src_pixel);
        items_taken++;
      end
      if (out_valid && out_ready) check_result();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !in_acc)) begin
      if (src_pixels_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_src_pixel <= src_pixels_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic push_pixel(input logic [bz2x_pkg::PIX_W-1:0] p);
    src_pixels_q.push_back(p);
    items_pushed++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (items_taken != items_pushed || upscaled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [bz2x_pkg::CFG_D_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [bz2x_pkg::CFG_D_W-1:0] wv,
                          input logic [bz2x_pkg::CFG_D_W-1:0] hv);
    write_reg(bz2x_pkg::REG_SRC_WIDTH, wv);
    write_reg(bz2x_pkg::REG_SRC_HEIGHT, hv);
    @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic press);
    int sent, w, h, n;
    logic [bz2x_pkg::CFG_D_W-1:0] wv, hv;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      wait_idle();
      if ($urandom_range(7) == 0) begin
        wv = bz2x_pkg::CFG_D_W'($urandom);
        hv = bz2x_pkg::CFG_D_W'($urandom);
        n = $urandom_range(1, 24);
      end else begin
        wv = bz2x_pkg::CFG_D_W'($urandom_range(2, 8));
        hv = bz2x_pkg::CFG_D_W'($urandom_range(2, 4));
        w = clamp_size(int'(wv[bz2x_pkg::SW_W-1:0]), bz2x_pkg::MAX_WIDTH);
        h = clamp_size(int'(hv), bz2x_pkg::MAX_HEIGHT);
        n = w * h + $urandom_range(0, w * h - 1);
      end
      if (press && sent == 0 && n < PRESS_ITEMS) n = PRESS_ITEMS;
      set_size(wv, hv);
      in_idle_pct = idle_pct;
      out_stall_pct = stall_pct;
      if (press && sent == 0) hold_req = ~hold_req;
      repeat (n) push_pixel(rand_pixel());
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'h0101_0101);
    push_pixel(32'hFF00_FF00);
    push_pixel(32'h00FF_00FF);
    wait_idle();
    set_size(13'h1001, 13'h0000);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'h01FE_01FE);
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);
    wait_idle();
    set_size(13'h1FFF, 13'h1FFF);
    repeat (3) push_pixel(rand_pixel());
    wait_idle();
    set_size(13'd2048, 13'd4096);
    repeat (2) push_pixel(rand_pixel());
    wait_idle();
    set_size(13'd3, 13'd3);
    repeat (9) push_pixel(rand_pixel());

    run_phase(0, 0, 1'b1);
    run_phase(74, 0, 1'b0);
    run_phase(0, 74, 1'b0);
    run_phase(11, 11, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0 && upscaled_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ bilinear_zoom_2x_rgba_top.f @@
rtl/core/bz2x_pkg.sv
rtl/core/bz2x_front.sv
rtl/core/bz2x_queue.sv
rtl/core/bz2x_back.sv
rtl/core/bilinear_zoom_2x_rgba_top.sv
tb/sv/testbench.sv
